@@ hw/rtl/mmcal_pkg.sv @@
// Shared types, widths and codes for the magnetometer min/max calibration block.
// No dependencies; every other file imports this package.

package mmcal_pkg;

  // Field widths fixed by the item and register formats
  localparam int SAMPLE_W  = 16;
  localparam int FRAC_W    = 12;
  localparam int TIME_W    = 32;
  localparam int CMD_W     = 2;
  localparam int STATUS_W  = 3;
  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 3;
  localparam int CNT_CFG_W = 16;
  localparam int HR_W      = 15;
  localparam int NUM_AXES  = 3;

  // Derived internal widths
  localparam int SCALE_W = FRAC_W + 4;        // Q4.12 axis scale
  localparam int BIAS_W  = SAMPLE_W + 2;      // max + min, one fraction bit, sign
  localparam int RANGE_W = SAMPLE_W + 1;      // max - min, signed
  localparam int COV_W   = FRAC_W + 1;        // Q1.12 coverage, up to unity
  localparam int DEN_W   = SAMPLE_W + 2;      // holds 3 * range and the range sum
  localparam int NUM_W   = DEN_W + FRAC_W;    // range sum shifted by the fraction

  localparam logic [SCALE_W-1:0] SCALE_ONE = {{3{1'b0}}, 1'b1, {FRAC_W{1'b0}}};

  // Register reset values
  localparam logic [CNT_CFG_W-1:0] MIN_COUNT_RST = 16'd500;
  localparam logic [HR_W-1:0]      MIN_HR_RST    = 15'd205;
  localparam logic [SCALE_W-1:0]   MIN_SCALE_RST = 16'd819;
  localparam logic [SCALE_W-1:0]   MAX_SCALE_RST = 16'd20480;
  localparam logic [TIME_W-1:0]    DURATION_RST  = 32'd30000;

  typedef enum logic [CMD_W-1:0] {
    CMD_START,
    CMD_SAMPLE,
    CMD_FINISH,
    CMD_APPLY
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    PH_IDLE,
    PH_COLLECT,
    PH_VALID,
    PH_FEW,
    PH_RANGE,
    PH_SCALE
  } phase_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MIN_COUNT,
    REG_MIN_HALF_RANGE,
    REG_MIN_SCALE,
    REG_MAX_SCALE,
    REG_DURATION
  } cfg_reg_e;

  // Control from the merge stage to every axis lane
  typedef struct packed {
    logic clear;    // back to reset extrema, bias and scale
    logic update;   // fold the sample into min/max
    logic apply;    // start the correction multiply
    logic use_cal;  // calibration in force for the multiply
    logic commit;   // load bias from extrema and the new scale
  } lane_ctrl_t;

endpackage

@@ hw/rtl/mmcal_if.sv @@
// Request and result channel interfaces with valid/ready handshake.
// Depends on mmcal_pkg for field widths.

interface mmcal_req_if import mmcal_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic [CMD_W-1:0]           command;
  logic [TIME_W-1:0]          time_ms;
  logic signed [SAMPLE_W-1:0] sample_x;
  logic signed [SAMPLE_W-1:0] sample_y;
  logic signed [SAMPLE_W-1:0] sample_z;

  modport source (output valid, command, time_ms, sample_x, sample_y, sample_z,
                  input ready);
  modport sink (input valid, command, time_ms, sample_x, sample_y, sample_z,
                output ready);
endinterface

interface mmcal_res_if import mmcal_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic [STATUS_W-1:0]        status;
  logic                       valid_res;
  logic                       time_complete;
  logic signed [SAMPLE_W-1:0] cal_x;
  logic signed [SAMPLE_W-1:0] cal_y;
  logic signed [SAMPLE_W-1:0] cal_z;
  logic [COV_W-1:0]           cover_ratio;

  modport source (output valid, status, valid_res, time_complete, cal_x,
                  cal_y, cal_z, cover_ratio, input ready);
  modport sink (input valid, status, valid_res, time_complete, cal_x,
                cal_y, cal_z, cover_ratio, output ready);
endinterface

@@ hw/rtl/magnetometer_minmax_calibration.sv @@
// Top level of the magnetometer min/max calibration block.
// Depends on mmcal_pkg, mmcal_if, mmcal_lane and mmcal_div.

// Three axis lanes track per-axis extrema and hold bias and scale; a merge
// stage checks the ranges and drives one shared divider for the three scale
// factors and the coverage figure. Start and sample requests may follow back
// to back. Apply runs one multiply per lane, registered, then rounding and
// saturation. Finish loads its result from the ready state when the sample
// count check fails, from the range state when the range or zero-range check
// fails, and otherwise after the 30-step radix-2 divider, run once per axis
// scale and once for coverage, or sooner if a scale is out of bounds. A new
// request is taken only when the output register is empty or its result
// leaves in the same cycle, and never while a finish or apply is in progress.

module magnetometer_minmax_calibration import mmcal_pkg::*; #(
  parameter int COUNT_WIDTH = 24
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  mmcal_req_if.sink            req_if,
  mmcal_res_if.source          res_if
);

  typedef enum logic [2:0] {
    C_READY,
    C_APPLY,
    C_RANGE,
    C_DIV_GO,
    C_DIV_WAIT
  } ctl_e;

  localparam logic [1:0] AX_COV = 2'd3;

  // Configuration
  logic [CNT_CFG_W-1:0] min_cnt_q, min_cnt_d;
  logic [HR_W-1:0]      min_hr_q, min_hr_d;
  logic [SCALE_W-1:0]   min_sc_q, min_sc_d;
  logic [SCALE_W-1:0]   max_sc_q, max_sc_d;
  logic [TIME_W-1:0]    dur_q, dur_d;

  // Calibration control state
  ctl_e                   ctl_q, ctl_d;
  phase_e                 phase_q, phase_d;
  logic                   valid_q, valid_d;
  logic [COUNT_WIDTH-1:0] count_q, count_d;
  logic [TIME_W-1:0]      start_q, start_d;
  logic [COV_W-1:0]       cov_q, cov_d;
  logic                   tc_q, tc_d;
  logic [1:0]             ax_q, ax_d;
  logic [DEN_W-1:0]       sum_q, sum_d;
  logic [SAMPLE_W-1:0]    dmin_q, dmin_d;
  logic [SAMPLE_W-1:0]    dmax_q, dmax_d;
  logic [SCALE_W-1:0]     sc_q [NUM_AXES];
  logic [SCALE_W-1:0]     sc_d [NUM_AXES];

  // Output register
  logic                       out_valid_q, out_valid_d;
  phase_e                     res_status_q, res_status_d;
  logic                       res_valid_q, res_valid_d;
  logic                       res_tc_q, res_tc_d;
  logic signed [SAMPLE_W-1:0] res_corr_q [NUM_AXES];
  logic signed [SAMPLE_W-1:0] res_corr_d [NUM_AXES];
  logic [COV_W-1:0]           res_cov_q, res_cov_d;

  // Lanes and divider
  lane_ctrl_t                 lane_ctrl;
  logic signed [SAMPLE_W-1:0] samp [NUM_AXES];
  logic signed [RANGE_W-1:0]  rng [NUM_AXES];
  logic signed [SAMPLE_W-1:0] corr [NUM_AXES];
  logic [SAMPLE_W-1:0]        mag [NUM_AXES];
  logic                       div_start;
  logic [NUM_W-1:0]           div_num;
  logic [DEN_W-1:0]           div_den;
  logic                       div_done;
  logic [NUM_W-1:0]           div_quo;

  // Merge-stage scratch
  logic                       accept;
  cmd_e                       cmd;
  logic [TIME_W-1:0]          elapsed;
  logic                       tc_now;
  logic signed [RANGE_W:0]    thr;
  logic                       range_fail;
  logic                       zero_fail;
  logic                       load;
  phase_e                     ld_status;
  logic                       ld_valid;
  logic                       ld_tc;
  logic [COV_W-1:0]           ld_cov;
  logic                       ld_corr;

  assign samp[0] = req_if.sample_x;
  assign samp[1] = req_if.sample_y;
  assign samp[2] = req_if.sample_z;

  assign req_if.ready = (ctl_q == C_READY) && (!out_valid_q || res_if.ready);
  assign accept       = req_if.valid && req_if.ready;
  assign cmd          = cmd_e'(req_if.command);

  for (genvar g = 0; g < NUM_AXES; g++) begin : g_lane
    mmcal_lane u_lane (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctrl_i   (lane_ctrl),
      .sample_i (samp[g]),
      .scale_i  (sc_q[g]),
      .range_o  (rng[g]),
      .corr_o   (corr[g])
    );
    assign mag[g] = rng[g][SAMPLE_W-1:0];
  end

  mmcal_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  // Range checks across the lanes
  always_comb begin
    thr        = $signed((RANGE_W+1)'({min_hr_q, 1'b0}));
    range_fail = 1'b0;
    zero_fail  = 1'b0;
    for (int i = 0; i < NUM_AXES; i++) begin
      if ($signed({rng[i][RANGE_W-1], rng[i]}) < thr) range_fail = 1'b1;
      if (rng[i] <= RANGE_W'(0)) zero_fail = 1'b1;
    end
  end

  // Divider operands: three axis scales, then coverage
  always_comb begin
    div_num = {sum_q, {FRAC_W{1'b0}}};
    case (ax_q)
      2'd0: div_den = DEN_W'(mag[0]) + DEN_W'({mag[0], 1'b0});
      2'd1: div_den = DEN_W'(mag[1]) + DEN_W'({mag[1], 1'b0});
      2'd2: div_den = DEN_W'(mag[2]) + DEN_W'({mag[2], 1'b0});
      default: begin
        div_num = NUM_W'({dmin_q, {FRAC_W{1'b0}}});
        div_den = DEN_W'(dmax_q);
      end
    endcase
  end

  // Request sequencing, state updates and result loading
  always_comb begin
    min_cnt_d = min_cnt_q;
    min_hr_d  = min_hr_q;
    min_sc_d  = min_sc_q;
    max_sc_d  = max_sc_q;
    dur_d     = dur_q;
    ctl_d     = ctl_q;
    phase_d   = phase_q;
    valid_d   = valid_q;
    count_d   = count_q;
    start_d   = start_q;
    cov_d     = cov_q;
    tc_d      = tc_q;
    ax_d      = ax_q;
    sum_d     = sum_q;
    dmin_d    = dmin_q;
    dmax_d    = dmax_q;
    sc_d      = sc_q;

    lane_ctrl         = '0;
    lane_ctrl.use_cal = valid_q;
    div_start         = 1'b0;

    load      = 1'b0;
    ld_status = phase_q;
    ld_valid  = valid_q;
    ld_tc     = 1'b0;
    ld_cov    = cov_q;
    ld_corr   = 1'b0;

    elapsed = req_if.time_ms - start_q;
    tc_now  = (phase_q == PH_COLLECT) && (elapsed >= dur_q);

    // Configuration writes
    if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_MIN_COUNT:      min_cnt_d = cfg_wdata_i[CNT_CFG_W-1:0];
        REG_MIN_HALF_RANGE: min_hr_d  = cfg_wdata_i[HR_W-1:0];
        REG_MIN_SCALE:      min_sc_d  = cfg_wdata_i[SCALE_W-1:0];
        REG_MAX_SCALE:      max_sc_d  = cfg_wdata_i[SCALE_W-1:0];
        REG_DURATION:       dur_d     = cfg_wdata_i[TIME_W-1:0];
        default: ;
      endcase
    end

    case (ctl_q)
      C_READY: begin
        if (accept) begin
          case (cmd)
            CMD_START: begin
              lane_ctrl.clear = 1'b1;
              phase_d   = PH_COLLECT;
              valid_d   = 1'b0;
              count_d   = '0;
              start_d   = req_if.time_ms;
              cov_d     = '0;
              load      = 1'b1;
              ld_status = PH_COLLECT;
              ld_valid  = 1'b0;
              ld_tc     = (dur_q == '0);
              ld_cov    = '0;
            end
            CMD_SAMPLE: begin
              if (phase_q == PH_COLLECT) begin
                lane_ctrl.update = 1'b1;
                if (!(&count_q)) count_d = count_q + COUNT_WIDTH'(1);
              end
              load  = 1'b1;
              ld_tc = tc_now;
            end
            CMD_FINISH: begin
              valid_d = 1'b0;
              if (count_q < COUNT_WIDTH'(min_cnt_q)) begin
                phase_d   = PH_FEW;
                load      = 1'b1;
                ld_status = PH_FEW;
                ld_valid  = 1'b0;
              end else begin
                ctl_d = C_RANGE;
              end
            end
            CMD_APPLY: begin
              lane_ctrl.apply = 1'b1;
              tc_d  = tc_now;
              ctl_d = C_APPLY;
            end
            default: ;
          endcase
        end
      end

      C_APPLY: begin
        load    = 1'b1;
        ld_tc   = tc_q;
        ld_corr = 1'b1;
        ctl_d   = C_READY;
      end

      C_RANGE: begin
        if (range_fail || zero_fail) begin
          phase_d   = range_fail ? PH_RANGE : PH_SCALE;
          load      = 1'b1;
          ld_status = range_fail ? PH_RANGE : PH_SCALE;
          ctl_d     = C_READY;
        end else begin
          sum_d  = DEN_W'(mag[0]) + DEN_W'(mag[1]) + DEN_W'(mag[2]);
          dmin_d = mag[0];
          dmax_d = mag[0];
          for (int i = 1; i < NUM_AXES; i++) begin
            if (mag[i] < dmin_d) dmin_d = mag[i];
            if (mag[i] > dmax_d) dmax_d = mag[i];
          end
          ax_d  = '0;
          ctl_d = C_DIV_GO;
        end
      end

      C_DIV_GO: begin
        div_start = 1'b1;
        ctl_d     = C_DIV_WAIT;
      end

      C_DIV_WAIT: begin
        if (div_done) begin
          if (ax_q != AX_COV) begin
            if (div_quo < NUM_W'(min_sc_q) || div_quo > NUM_W'(max_sc_q)) begin
              phase_d   = PH_SCALE;
              load      = 1'b1;
              ld_status = PH_SCALE;
              ctl_d     = C_READY;
            end else begin
              for (int i = 0; i < NUM_AXES; i++) begin
                if (ax_q == 2'(i)) begin
                  sc_d[i] = (div_quo > NUM_W'({SCALE_W{1'b1}})) ?
                            {SCALE_W{1'b1}} : div_quo[SCALE_W-1:0];
                end
              end
              ax_d  = ax_q + 2'd1;
              ctl_d = C_DIV_GO;
            end
          end else begin
            lane_ctrl.commit = 1'b1;
            cov_d     = div_quo[COV_W-1:0];
            valid_d   = 1'b1;
            phase_d   = PH_VALID;
            load      = 1'b1;
            ld_status = PH_VALID;
            ld_valid  = 1'b1;
            ld_cov    = div_quo[COV_W-1:0];
            ctl_d     = C_READY;
          end
        end
      end

      default: ctl_d = C_READY;
    endcase

    // Output register: drain on take, fill on load
    out_valid_d  = out_valid_q && !res_if.ready;
    res_status_d = res_status_q;
    res_valid_d  = res_valid_q;
    res_tc_d     = res_tc_q;
    res_cov_d    = res_cov_q;
    res_corr_d   = res_corr_q;
    if (load) begin
      out_valid_d  = 1'b1;
      res_status_d = ld_status;
      res_valid_d  = ld_valid;
      res_tc_d     = ld_tc;
      res_cov_d    = ld_cov;
      for (int i = 0; i < NUM_AXES; i++) begin
        res_corr_d[i] = ld_corr ? corr[i] : SAMPLE_W'(0);
      end
    end
  end

  // State and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_cnt_q    <= MIN_COUNT_RST;
      min_hr_q     <= MIN_HR_RST;
      min_sc_q     <= MIN_SCALE_RST;
      max_sc_q     <= MAX_SCALE_RST;
      dur_q        <= DURATION_RST;
      ctl_q        <= C_READY;
      phase_q      <= PH_IDLE;
      valid_q      <= 1'b0;
      count_q      <= '0;
      start_q      <= '0;
      cov_q        <= '0;
      tc_q         <= 1'b0;
      ax_q         <= '0;
      sum_q        <= '0;
      dmin_q       <= '0;
      dmax_q       <= '0;
      sc_q         <= '{default: '0};
      out_valid_q  <= 1'b0;
      res_status_q <= PH_IDLE;
      res_valid_q  <= 1'b0;
      res_tc_q     <= 1'b0;
      res_cov_q    <= '0;
      res_corr_q   <= '{default: '0};
    end else begin
      min_cnt_q    <= min_cnt_d;
      min_hr_q     <= min_hr_d;
      min_sc_q     <= min_sc_d;
      max_sc_q     <= max_sc_d;
      dur_q        <= dur_d;
      ctl_q        <= ctl_d;
      phase_q      <= phase_d;
      valid_q      <= valid_d;
      count_q      <= count_d;
      start_q      <= start_d;
      cov_q        <= cov_d;
      tc_q         <= tc_d;
      ax_q         <= ax_d;
      sum_q        <= sum_d;
      dmin_q       <= dmin_d;
      dmax_q       <= dmax_d;
      sc_q         <= sc_d;
      out_valid_q  <= out_valid_d;
      res_status_q <= res_status_d;
      res_valid_q  <= res_valid_d;
      res_tc_q     <= res_tc_d;
      res_cov_q    <= res_cov_d;
      res_corr_q   <= res_corr_d;
    end
  end

  assign res_if.valid         = out_valid_q;
  assign res_if.status        = res_status_q;
  assign res_if.valid_res     = res_valid_q;
  assign res_if.time_complete = res_tc_q;
  assign res_if.cal_x         = res_corr_q[0];
  assign res_if.cal_y         = res_corr_q[1];
  assign res_if.cal_z         = res_corr_q[2];
  assign res_if.cover_ratio   = res_cov_q;

endmodule

@@ hw/rtl/mmcal_div.sv @@
// Shared radix-2 restoring divider, one quotient bit per cycle.
// Depends on mmcal_pkg for operand widths.

module mmcal_div import mmcal_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             done_o,
  output logic [NUM_W-1:0] quo_o
);

  localparam int STEP_W = $clog2(NUM_W + 1);

  logic              busy_q;
  logic              done_q;
  logic [STEP_W-1:0] cnt_q;
  logic [NUM_W-1:0]  quo_q;
  logic [DEN_W-1:0]  rem_q;
  logic [DEN_W-1:0]  den_q;

  logic [DEN_W:0]    rem_sh;
  logic [DEN_W:0]    rem_sub;
  logic              fits;

  // Shift in the next numerator bit and try the subtract
  always_comb begin
    rem_sh  = {rem_q, quo_q[NUM_W-1]};
    rem_sub = rem_sh - {1'b0, den_q};
    fits    = rem_sh >= {1'b0, den_q};
  end

  // Sequence control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= STEP_W'(NUM_W);
    end else if (busy_q) begin
      cnt_q <= cnt_q - STEP_W'(1);
      if (cnt_q == STEP_W'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  // Remainder and quotient datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= num_i;
      rem_q <= '0;
      den_q <= den_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[NUM_W-2:0], fits};
      rem_q <= fits ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

@@ hw/rtl/mmcal_lane.sv @@
// One axis lane: min/max tracking, bias and scale storage, correction multiply.
// Depends on mmcal_pkg for widths and the lane control struct.

module mmcal_lane import mmcal_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  lane_ctrl_t                 ctrl_i,
  input  logic signed [SAMPLE_W-1:0] sample_i,
  input  logic [SCALE_W-1:0]         scale_i,
  output logic signed [RANGE_W-1:0]  range_o,
  output logic signed [SAMPLE_W-1:0] corr_o
);

  localparam int PROD_W = BIAS_W + SCALE_W + 1;
  localparam int SHIFT  = FRAC_W + 1;
  localparam logic signed [PROD_W-1:0] SAT_HI =
    {{(PROD_W-SAMPLE_W+1){1'b0}}, {(SAMPLE_W-1){1'b1}}};
  localparam logic signed [PROD_W-1:0] SAT_LO = ~SAT_HI;
  localparam logic signed [PROD_W-1:0] RND_ADJ =
    {{(PROD_W-SHIFT){1'b0}}, {SHIFT{1'b1}}};
  localparam logic signed [SAMPLE_W-1:0] S_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam logic signed [SAMPLE_W-1:0] S_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

  logic signed [SAMPLE_W-1:0] min_q;
  logic signed [SAMPLE_W-1:0] max_q;
  logic signed [BIAS_W-1:0]   bias_q;
  logic [SCALE_W-1:0]         scale_q;
  logic signed [PROD_W-1:0]   prod_q;

  logic signed [RANGE_W-1:0]  ext_sum;
  logic signed [BIAS_W-1:0]   diff;
  logic signed [SCALE_W:0]    factor;
  logic signed [PROD_W-1:0]   prod_d;
  logic signed [PROD_W-1:0]   adj;
  logic signed [PROD_W-1:0]   quo;

  // Range and bias from the extrema
  always_comb begin
    range_o = {max_q[SAMPLE_W-1], max_q} - {min_q[SAMPLE_W-1], min_q};
    ext_sum = {max_q[SAMPLE_W-1], max_q} + {min_q[SAMPLE_W-1], min_q};
  end

  // (2*raw - bias) * scale; unity and zero bias pass the raw value through
  always_comb begin
    diff   = {sample_i[SAMPLE_W-1], sample_i, 1'b0}
             - (ctrl_i.use_cal ? bias_q : BIAS_W'(0));
    factor = $signed({1'b0, (ctrl_i.use_cal ? scale_q : SCALE_ONE)});
    prod_d = diff * factor;
  end

  // Truncate toward zero, then saturate to the sample range
  always_comb begin
    adj = prod_q + (prod_q[PROD_W-1] ? RND_ADJ : PROD_W'(0));
    quo = adj >>> SHIFT;
    if (quo > SAT_HI) begin
      corr_o = S_MAX;
    end else if (quo < SAT_LO) begin
      corr_o = S_MIN;
    end else begin
      corr_o = quo[SAMPLE_W-1:0];
    end
  end

  // Calibration state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q   <= S_MAX;
      max_q   <= S_MIN;
      bias_q  <= '0;
      scale_q <= SCALE_ONE;
    end else if (ctrl_i.clear) begin
      min_q   <= S_MAX;
      max_q   <= S_MIN;
      bias_q  <= '0;
      scale_q <= SCALE_ONE;
    end else begin
      if (ctrl_i.update) begin
        if (sample_i < min_q) min_q <= sample_i;
        if (sample_i > max_q) max_q <= sample_i;
      end
      if (ctrl_i.commit) begin
        bias_q  <= {ext_sum[RANGE_W-1], ext_sum};
        scale_q <= scale_i;
      end
    end
  end

  // Product register
  always_ff @(posedge clk_i) begin
    if (ctrl_i.apply) begin
      prod_q <= prod_d;
    end
  end

endmodule
